// ----- rtl/gtq_pkg.sv -----
// Package for the two-link gravity torque unit: fixed-point widths, angle constants,
// register indexes, the CORDIC pipeline word and the arctangent table.
// No dependencies.
package gtq_pkg;

	// Width of the CORDIC x, y and z words (Q2.30 plus guard bits).
	localparam int CW = 34;
	// Width of the link products (m1+m2)*l1*g and m2*g*l2.
	localparam int PW = 49;
	// Width of one rounded torque term.
	localparam int TW = 31;
	// Most CORDIC stages that the arctangent table supports.
	localparam int MAX_STAGES = 24;

	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_MASS1 = 3'd0;
	localparam logic [2:0] REG_MASS2 = 3'd1;
	localparam logic [2:0] REG_LEN1  = 3'd2;
	localparam logic [2:0] REG_LEN2  = 3'd3;
	localparam logic [2:0] REG_GRAV  = 3'd4;

	localparam logic [15:0] MASS1_RST = 16'd256;
	localparam logic [15:0] MASS2_RST = 16'd256;
	localparam logic [15:0] LEN1_RST  = 16'd4096;
	localparam logic [15:0] LEN2_RST  = 16'd4096;
	localparam logic [15:0] GRAV_RST  = 16'd2511;

	// Angles in Q3.13, carried on 18 bits during reduction.
	localparam logic signed [17:0] ANG_PI      = 18'sd25736;
	localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;
	localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} cord_t;

	// Both cosines of one item travel side by side through the cell row.
	typedef struct packed {
		cord_t q1;
		cord_t q12;
	} cord_pair_t;

	function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
		logic signed [CW-1:0] r;
		unique case (idx)
			0:  r = 34'sd843314857;
			1:  r = 34'sd497837829;
			2:  r = 34'sd263043837;
			3:  r = 34'sd133525159;
			4:  r = 34'sd67021687;
			5:  r = 34'sd33543516;
			6:  r = 34'sd16775851;
			7:  r = 34'sd8388437;
			8:  r = 34'sd4194283;
			9:  r = 34'sd2097149;
			10: r = 34'sd1048576;
			11: r = 34'sd524288;
			12: r = 34'sd262144;
			13: r = 34'sd131072;
			14: r = 34'sd65536;
			15: r = 34'sd32768;
			16: r = 34'sd16384;
			17: r = 34'sd8192;
			18: r = 34'sd4096;
			19: r = 34'sd2048;
			20: r = 34'sd1024;
			21: r = 34'sd512;
			22: r = 34'sd256;
			23: r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Wraps a 17-bit angle into [-pi, pi], folds it into [-pi/2, pi/2] and
	// forms the starting vector of the rotation.
	function automatic cord_t cord_init(input logic signed [16:0] ang);
		logic signed [17:0] t;
		cord_t c;
		t = {ang[16], ang};
		c.flip = 1'b0;
		if (t > ANG_PI) begin
			t = t - ANG_TWO_PI;
		end else if (t < -ANG_PI) begin
			t = t + ANG_TWO_PI;
		end
		if (t > ANG_HALF_PI) begin
			t = t - ANG_PI;
			c.flip = 1'b1;
		end else if (t < -ANG_HALF_PI) begin
			t = t + ANG_PI;
			c.flip = 1'b1;
		end
		c.x = CORDIC_GAIN;
		c.y = '0;
		c.z = {t[15], t[15:0], 17'b0};
		return c;
	endfunction

endpackage

// ----- rtl/gtq_cordic_cell.sv -----
// One rotation-mode CORDIC cell: rotates both cosine lanes by one micro-angle.
// Depends on gtq_pkg (pipeline word and arctangent table).
module gtq_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  gtq_pkg::cord_pair_t in_pair,
	output logic               out_vld,
	output gtq_pkg::cord_pair_t out_pair
);

	logic                vld_q;
	gtq_pkg::cord_pair_t pair_q;

	function automatic gtq_pkg::cord_t rotate(input gtq_pkg::cord_t c);
		gtq_pkg::cord_t       r;
		logic signed [gtq_pkg::CW-1:0] xs;
		logic signed [gtq_pkg::CW-1:0] ys;
		xs = c.x >>> STAGE;
		ys = c.y >>> STAGE;
		r.flip = c.flip;
		if (!c.z[gtq_pkg::CW-1]) begin
			r.x = c.x - ys;
			r.y = c.y + xs;
			r.z = c.z - gtq_pkg::atan_q30(STAGE);
		end else begin
			r.x = c.x + ys;
			r.y = c.y - xs;
			r.z = c.z + gtq_pkg::atan_q30(STAGE);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		pair_q.q1  <= rotate(in_pair.q1);
		pair_q.q12 <= rotate(in_pair.q12);
	end

	assign out_vld  = vld_q;
	assign out_pair = pair_q;

endmodule

// ----- rtl/gtq_term.sv -----
// Scales a link product by a cosine magnitude and rounds half away from zero to Q.8.
// The wide product is split into two partial products over two stages. Uses gtq_pkg.
module gtq_term (
	input  logic                          clk,
	input  logic [gtq_pkg::PW-1:0]        prod,
	input  logic [14:0]                   cmag,
	input  logic                          cneg,
	output logic signed [gtq_pkg::TW-1:0] term
);

	logic [46:0]                   lo_s1;
	logic [31:0]                   hi_s1;
	logic                          neg_s1;
	logic [63:0]                   full;
	logic [29:0]                   mag;
	logic signed [gtq_pkg::TW-1:0] term_s2;

	always_ff @(posedge clk) begin
		lo_s1  <= 47'(prod[31:0]) * 47'(cmag);
		hi_s1  <= 32'(prod[gtq_pkg::PW-1:32]) * 32'(cmag);
		neg_s1 <= cneg;
	end

	// Adding one half of the output step before truncating rounds the magnitude half up.
	assign full = {hi_s1, 32'b0} + 64'(lo_s1) + 64'h2_0000_0000;
	assign mag  = full[63:34];

	always_ff @(posedge clk) begin
		term_s2 <= neg_s1 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	assign term = term_s2;

endmodule

// ----- rtl/two_link_gravity_torque_unit.sv -----
// Top level of the two-link gravity torque unit: APB registers, angle reduction,
// a row of CORDIC cells, cosine rounding, term scaling and the torque sum.
// Depends on gtq_pkg, gtq_cordic_cell and gtq_term.
//
//  channel   | signals                                  | transfer
//  ----------+------------------------------------------+-------------------------------
//  angles    | start, busy, joint1_angle, joint2_angle  | start high while busy is low
//  torques   | done, torque_joint1, torque_joint2       | done high for one cycle
//  registers | psel, penable, pwrite, paddr, pwdata,    | psel, penable, pwrite, pready
//            | prdata, pready                           |
//
// A new angle pair can be taken in every cycle; busy stays low.
// Each item is registered after angle reduction, after every CORDIC cell (CORDIC_STAGES
// capped at 24), after cosine rounding, after each half of the split product and
// after the final sum, where the torques appear.
// Reset clears the register file to its defaults and empties the pipeline.
// Results cannot be held off; each is shown for exactly one cycle.
module two_link_gravity_torque_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [15:0]          joint1_angle,
	input  logic signed [15:0]          joint2_angle,
	output logic                        done,
	output logic signed [31:0]          torque_joint1,
	output logic signed [31:0]          torque_joint2,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gtq_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int NSTAGE = (CORDIC_STAGES > gtq_pkg::MAX_STAGES) ?
		gtq_pkg::MAX_STAGES : CORDIC_STAGES;

	logic [15:0] mass1_q;
	logic [15:0] mass2_q;
	logic [15:0] len1_q;
	logic [15:0] len2_q;
	logic [15:0] grav_q;
	logic        wr_en;

	logic [16:0]                msum;
	logic [32:0]                a1_q;
	logic [31:0]                a2_q;
	logic [gtq_pkg::PW-1:0]     p1_q;
	logic [gtq_pkg::PW-1:0]     p2_q;

	logic                       accept;
	logic signed [16:0]         ang_sum;
	logic                       vld_s1;
	gtq_pkg::cord_pair_t        pair_s1;

	logic                       vld_bus  [0:NSTAGE];
	gtq_pkg::cord_pair_t        pair_bus [0:NSTAGE];

	logic                       cos_vld_q;
	logic [14:0]                c1_mag_q;
	logic                       c1_neg_q;
	logic [14:0]                c12_mag_q;
	logic                       c12_neg_q;
	logic                       mul_vld_q;
	logic                       rnd_vld_q;
	logic signed [gtq_pkg::TW-1:0] term1;
	logic signed [gtq_pkg::TW-1:0] term2;
	logic                       done_q;
	logic signed [31:0]         tq1_q;
	logic signed [31:0]         tq2_q;

	// Rounds the final x to Q1.14, clamps it to plus or minus one and returns the
	// sign (with the fold applied) above the magnitude.
	function automatic logic [15:0] cos_round(input gtq_pkg::cord_t c);
		logic signed [gtq_pkg::CW-1:0] xr;
		logic signed [17:0]            v;
		logic [14:0]                   m;
		xr = c.x + 34'sd32768;
		v  = xr[gtq_pkg::CW-1:16];
		if (v > 18'sd16384) begin
			v = 18'sd16384;
		end else if (v < -18'sd16384) begin
			v = -18'sd16384;
		end
		m = v[17] ? 15'(-v) : v[14:0];
		return {v[17] ^ c.flip, m};
	endfunction

	// ---------------- register file ----------------
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass1_q <= gtq_pkg::MASS1_RST;
			mass2_q <= gtq_pkg::MASS2_RST;
			len1_q  <= gtq_pkg::LEN1_RST;
			len2_q  <= gtq_pkg::LEN2_RST;
			grav_q  <= gtq_pkg::GRAV_RST;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				gtq_pkg::REG_MASS1: mass1_q <= pwdata[15:0];
				gtq_pkg::REG_MASS2: mass2_q <= pwdata[15:0];
				gtq_pkg::REG_LEN1:  len1_q  <= pwdata[15:0];
				gtq_pkg::REG_LEN2:  len2_q  <= pwdata[15:0];
				gtq_pkg::REG_GRAV:  grav_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			gtq_pkg::REG_MASS1: prdata = {16'b0, mass1_q};
			gtq_pkg::REG_MASS2: prdata = {16'b0, mass2_q};
			gtq_pkg::REG_LEN1:  prdata = {16'b0, len1_q};
			gtq_pkg::REG_LEN2:  prdata = {16'b0, len2_q};
			gtq_pkg::REG_GRAV:  prdata = {16'b0, grav_q};
			default:            prdata = '0;
		endcase
	end

	// The link products follow the registers through a1_q/a2_q and then p1_q/p2_q. An item
	// needs them only after the full CORDIC row, so they are always settled.
	assign msum = 17'(mass1_q) + 17'(mass2_q);

	always_ff @(posedge clk) begin
		a1_q <= 33'(msum) * 33'(len1_q);
		a2_q <= 32'(mass2_q) * 32'(len2_q);
		p1_q <= gtq_pkg::PW'(a1_q) * gtq_pkg::PW'(grav_q);
		p2_q <= gtq_pkg::PW'(a2_q) * gtq_pkg::PW'(grav_q);
	end

	// ---------------- angle reduction ----------------
	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign ang_sum = 17'(joint1_angle) + 17'(joint2_angle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		pair_s1.q1  <= gtq_pkg::cord_init(17'(joint1_angle));
		pair_s1.q12 <= gtq_pkg::cord_init(ang_sum);
	end

	// ---------------- CORDIC cell row ----------------
	assign vld_bus[0]  = vld_s1;
	assign pair_bus[0] = pair_s1;

	for (genvar i = 0; i < NSTAGE; i++) begin : g_cell
		gtq_cordic_cell #(
			.STAGE(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vld_bus[i]),
			.in_pair (pair_bus[i]),
			.out_vld (vld_bus[i+1]),
			.out_pair(pair_bus[i+1])
		);
	end

	// ---------------- cosine rounding ----------------
	always_ff @(posedge clk) begin
		{c1_neg_q, c1_mag_q}   <= cos_round(pair_bus[NSTAGE].q1);
		{c12_neg_q, c12_mag_q} <= cos_round(pair_bus[NSTAGE].q12);
	end

	// ---------------- term scaling ----------------
	gtq_term u_term1 (
		.clk (clk),
		.prod(p1_q),
		.cmag(c1_mag_q),
		.cneg(c1_neg_q),
		.term(term1)
	);

	gtq_term u_term2 (
		.clk (clk),
		.prod(p2_q),
		.cmag(c12_mag_q),
		.cneg(c12_neg_q),
		.term(term2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_vld_q <= 1'b0;
			mul_vld_q <= 1'b0;
			rnd_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			cos_vld_q <= vld_bus[NSTAGE];
			mul_vld_q <= cos_vld_q;
			rnd_vld_q <= mul_vld_q;
			done_q    <= rnd_vld_q;
		end
	end

	// Each term stays below 2^30 in magnitude, so the 32-bit sum cannot overflow
	// and the saturation bound is never reached.
	always_ff @(posedge clk) begin
		tq1_q <= 32'(term1) + 32'(term2);
		tq2_q <= 32'(term2);
	end

	assign done          = done_q;
	assign torque_joint1 = tq1_q;
	assign torque_joint2 = tq2_q;

endmodule

// ----- rtl/gtq_checker.sv -----
// Port-level checker for the two-link gravity torque unit and its bind statement.
// Depends on gtq_pkg for the address width.
module gtq_checker #(
	parameter int CORDIC_STAGES = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [gtq_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata,
	input logic                       pready
);

	localparam int NSTAGE = (CORDIC_STAGES > gtq_pkg::MAX_STAGES) ?
		gtq_pkg::MAX_STAGES : CORDIC_STAGES;
	localparam int LAT = NSTAGE + 5;

	// Every accepted pair gives its torques, marked by done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("no result after an accepted angle pair");

	// No result appears without an accepted pair at the matching earlier edge.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, LAT))
		else $error("result without an accepted angle pair");

	// The unit never stalls either channel.
	a_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && pready)
		else $error("busy or pready held off a transfer");

	// A register reads back the low half of the last value written to it.
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && !pwrite && $past(psel && penable && pwrite && pready)
			&& paddr == $past(paddr) && paddr[4:2] <= gtq_pkg::REG_GRAV)
		|-> prdata == {16'b0, $past(pwdata[15:0])})
		else $error("register read back differs from the value written");

endmodule

bind two_link_gravity_torque_unit gtq_checker #(
	.CORDIC_STAGES(CORDIC_STAGES)
) u_gtq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.psel   (psel),
	.penable(penable),
	.pwrite (pwrite),
	.paddr  (paddr),
	.pwdata (pwdata),
	.prdata (prdata),
	.pready (pready)
);

// ----- dv/two_link_gravity_torque_unit_tb.sv -----
// Self-checking testbench for two_link_gravity_torque_unit: random and corner angle pairs
// against a built-in fixed-point predictor, with register programming over APB.
// Depends on gtq_pkg and the RTL of the unit.
module two_link_gravity_torque_unit_tb;

	localparam int STAGES = 16;
	localparam int LATENCY = (STAGES < 24 ? STAGES : 24) + 5;
	localparam int NUM_REGS = 2 ** 3;

	// Q3.13 angle landmarks and the CORDIC constants in Q2.30.
	localparam int HALF_TURN = 25736;
	localparam int QUARTER_TURN = 12868;
	localparam int FULL_TURN = 51472;
	localparam longint UNIT_GAIN_Q30 = 652032874;
	localparam longint ARCTAN_Q30 [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};

	localparam int NUM_CORNERS = 23;
	localparam int CORNER_SHOULDER [NUM_CORNERS] = '{
		0, 25736, -25736, 12868, -12868, 12869, -12869, 12867, 0, 25736, -25736,
		32767, -32768, 32767, -32768, -32768, 21845, 8192, 1, 25736, 12868, -12868,
		25735
	};
	localparam int CORNER_ELBOW [NUM_CORNERS] = '{
		0, 0, 0, 0, 0, 0, 0, 0, 25736, 25736, -25736,
		32767, -32768, 0, 0, 32767, -21846, -8192, -1, -25736, 12868, -12868,
		1
	};

	typedef struct packed {
		logic signed [15:0] shoulder;
		logic signed [15:0] elbow;
	} angle_pair_t;

	typedef struct packed {
		logic signed [31:0] shoulder;
		logic signed [31:0] elbow;
	} torque_pair_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic signed [15:0]         joint1_angle = '0;
	logic signed [15:0]         joint2_angle = '0;
	logic                       done;
	logic signed [31:0]         torque_joint1;
	logic signed [31:0]         torque_joint2;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [gtq_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                pwdata = '0;
	logic [31:0]                prdata;
	logic                       pready;

	// Register copy of the predictor, indexed like the register map.
	logic [15:0] arm_regs [5] = '{
		16'd256, 16'd256, 16'd4096, 16'd4096, 16'd2511
	};

	angle_pair_t  angle_pair_q [$];
	torque_pair_t torque_expect_q [$];
	torque_pair_t oldest_torque;
	int           idle_pct = 0;
	int           error_count = 0;

	two_link_gravity_torque_unit #(
		.CORDIC_STAGES(STAGES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.joint1_angle (joint1_angle),
		.joint2_angle (joint2_angle),
		.done         (done),
		.torque_joint1(torque_joint1),
		.torque_joint2(torque_joint2),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #4 clk = ~clk;

	// Cosine of a Q3.13 angle in Q1.14: wrap, fold into the right half plane, rotate.
	function automatic longint cosine_q14(input int ang);
		int     t;
		bit     flip;
		longint x, y, z, nx, c;
		t = ang;
		flip = 1'b0;
		for (int n = 0; n < 4 && t > HALF_TURN; n++) t -= FULL_TURN;
		for (int n = 0; n < 4 && t < -HALF_TURN; n++) t += FULL_TURN;
		if (t > QUARTER_TURN) begin
			t -= HALF_TURN;
			flip = 1'b1;
		end else if (t < -QUARTER_TURN) begin
			t += HALF_TURN;
			flip = 1'b1;
		end
		x = UNIT_GAIN_Q30;
		y = 0;
		z = longint'(t) * 131072;
		for (int i = 0; i < STAGES && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ARCTAN_Q30[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ARCTAN_Q30[i];
			end
			x = nx;
		end
		c = (x + 32768) >>> 16;
		if (c > 16384) c = 16384;
		if (c < -16384) c = -16384;
		return flip ? -c : c;
	endfunction

	// Product in Q.28 times a Q1.14 cosine, rounded half away from zero to Q.8.
	function automatic longint rounded_term(input longint unsigned prod, input longint c);
		longint unsigned mag;
		mag = prod * longint'(c < 0 ? -c : c);
		mag = (mag + (64'd1 << 33)) >> 34;
		return c < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic torque_pair_t predict_torques(input logic signed [15:0] q1,
			input logic signed [15:0] q2);
		longint unsigned p_shoulder, p_elbow;
		longint          t_elbow, t_shoulder;
		torque_pair_t    r;
		p_shoulder = (64'(arm_regs[gtq_pkg::REG_MASS1]) + 64'(arm_regs[gtq_pkg::REG_MASS2]))
			* 64'(arm_regs[gtq_pkg::REG_LEN1]) * 64'(arm_regs[gtq_pkg::REG_GRAV]);
		p_elbow = 64'(arm_regs[gtq_pkg::REG_MASS2]) * 64'(arm_regs[gtq_pkg::REG_GRAV])
			* 64'(arm_regs[gtq_pkg::REG_LEN2]);
		t_elbow = rounded_term(p_elbow, cosine_q14(int'(q1) + int'(q2)));
		t_shoulder = rounded_term(p_shoulder, cosine_q14(int'(q1))) + t_elbow;
		r.shoulder = clamp32(t_shoulder);
		r.elbow = clamp32(t_elbow);
		return r;
	endfunction

	// Mostly in-range angles, some near the fold points, the rest any 16-bit pattern.
	function automatic logic signed [15:0] random_angle();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: v = int'($urandom_range(2 * HALF_TURN)) - HALF_TURN;
			6: begin
				case ($urandom_range(3))
					0: v = HALF_TURN;
					1: v = -HALF_TURN;
					2: v = QUARTER_TURN;
					default: v = -QUARTER_TURN;
				endcase
				v = v + int'($urandom_range(4)) - 2;
			end
			default: v = int'($urandom());
		endcase
		return v[15:0];
	endfunction

	function automatic logic [15:0] random_setting();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom_range(4096));
			default: return 16'($urandom());
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			joint1_angle <= '0;
			joint2_angle <= '0;
		end else begin
			if (start && !busy) begin
				torque_expect_q.push_back(predict_torques(joint1_angle, joint2_angle));
			end
			if (!start || !busy) begin
				if (angle_pair_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					joint1_angle <= angle_pair_q[0].shoulder;
					joint2_angle <= angle_pair_q[0].elbow;
					void'(angle_pair_q.pop_front());
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (torque_expect_q.size() == 0) begin
				$display("%0t: torque transfer with nothing expected: %0d %0d",
					$time, torque_joint1, torque_joint2);
				error_count++;
			end else begin
				oldest_torque = torque_expect_q.pop_front();
				if (torque_joint1 !== oldest_torque.shoulder) begin
					$display("%0t: torque_joint1 expected %0d got %0d",
						$time, oldest_torque.shoulder, torque_joint1);
					error_count++;
				end
				if (torque_joint2 !== oldest_torque.elbow) begin
					$display("%0t: torque_joint2 expected %0d got %0d",
						$time, oldest_torque.elbow, torque_joint2);
					error_count++;
				end
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// Upper bits carry noise; only the low half is meant to land.
		pwdata <= {16'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx <= gtq_pkg::REG_GRAV) arm_regs[idx] = value;
	endtask

	task automatic check_regs();
		logic [15:0] got;
		for (int k = 0; k <= gtq_pkg::REG_GRAV; k++) begin
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {3'(k), 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			@(negedge clk);
			got = prdata[15:0];
			@(posedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			if (got !== arm_regs[k]) begin
				$display("%0t: register %0d expected %0d got %0d", $time, k, arm_regs[k], got);
				error_count++;
			end
		end
	endtask

	task automatic load_setting(input logic [15:0] m1, input logic [15:0] m2,
			input logic [15:0] l1, input logic [15:0] l2, input logic [15:0] g);
		reg_write(gtq_pkg::REG_MASS1, m1);
		reg_write(gtq_pkg::REG_MASS2, m2);
		reg_write(gtq_pkg::REG_LEN1, l1);
		reg_write(gtq_pkg::REG_LEN2, l2);
		reg_write(gtq_pkg::REG_GRAV, g);
		check_regs();
	endtask

	// Returns once every queued pair has been sent and every torque pair has come back.
	task automatic drain();
		do @(negedge clk); while (angle_pair_q.size() != 0 || start || torque_expect_q.size() != 0);
	endtask

	task automatic run_random(input int count, input int idle);
		idle_pct = idle;
		repeat (count) angle_pair_q.push_back(angle_pair_t'{random_angle(), random_angle()});
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_regs();

		idle_pct = 0;
		for (int k = 0; k < NUM_CORNERS; k++) begin
			angle_pair_q.push_back(angle_pair_t'{16'(CORNER_SHOULDER[k]), 16'(CORNER_ELBOW[k])});
		end
		drain();

		// Writes outside the register map must leave every register untouched.
		for (int k = gtq_pkg::REG_GRAV + 1; k < NUM_REGS; k++) reg_write(3'(k), 16'($urandom()));
		check_regs();
		run_random(150, 0);

		load_setting(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		run_random(150, 88);
		load_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(60, 26);
		load_setting(16'd0, 16'hffff, 16'hffff, 16'd0, 16'hffff);
		run_random(60, 0);

		for (int ph = 0; ph < 4; ph++) begin
			load_setting(random_setting(), random_setting(), random_setting(),
				random_setting(), random_setting());
			case (ph)
				0: run_random(170, 0);
				1: run_random(170, 88);
				2: run_random(170, 26);
				default: run_random(170, 88);
			endcase
		end

		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/gtq_pkg.sv
rtl/gtq_cordic_cell.sv
rtl/gtq_term.sv
rtl/two_link_gravity_torque_unit.sv
rtl/gtq_checker.sv
dv/two_link_gravity_torque_unit_tb.sv
